[design/multichannel_waveform_player_unit_defines.svh]
// Assertion macros shared by the checker of the waveform player
`ifndef MULTICHANNEL_WAVEFORM_PLAYER_UNIT_DEFINES_SVH
`define MULTICHANNEL_WAVEFORM_PLAYER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset
`define MWP_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("waveform player: same-cycle port rule violated");

// Next-cycle implication, sampled on the rising clock edge, off during reset
`define MWP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("waveform player: next-cycle port rule violated");

`endif

[design/mwp_pkg.sv]
// Package of the waveform player: sizes, item kinds and channel state record
package mwp_pkg;

   localparam int CHANNELS   = 16;
   localparam int MAX_POINTS = 1024;
   localparam int FRAME_CAP  = 16;
   localparam int FRAME      = (CHANNELS < FRAME_CAP) ? CHANNELS : FRAME_CAP;

   // transaction field widths
   localparam int KIND_W       = 2;
   localparam int CHAN_FIELD_W = 4;
   localparam int INDEX_W      = 10;
   localparam int VALUE_W      = 16;
   localparam int LENGTH_W     = 16;

   // derived internal widths
   localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int PT_W       = $clog2(MAX_POINTS);
   localparam int LEN_W      = $clog2(MAX_POINTS + 1);
   localparam int WAVE_DEPTH = CHANNELS * MAX_POINTS;
   localparam int WA_W       = $clog2(WAVE_DEPTH);

   typedef enum logic [1:0] {
      KIND_TICK  = 2'd0,
      KIND_WRITE = 2'd1,
      KIND_WAVE  = 2'd2,
      KIND_FIXED = 2'd3
   } kind_type;

   // one entry of the channel state memory
   typedef struct packed {
      logic               mode;
      logic [LEN_W-1:0]   length;
      logic [PT_W-1:0]    counter;
      logic [VALUE_W-1:0] level;
   } chan_state_type;

   localparam int CS_W = $bits(chan_state_type);

   localparam chan_state_type CHAN_RESET = '{
      mode:    1'b0,
      length:  LEN_W'(1),
      counter: '0,
      level:   '0
   };

   // access request to the channel state store
   typedef struct packed {
      logic           rd_en;
      logic [CH_W-1:0] rd_addr;
      logic           wr_en;
      logic [CH_W-1:0] wr_addr;
      chan_state_type wr_data;
   } chan_access_type;

endpackage

[design/mwp_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read
module mwp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/mwp_chan_store.sv]
// Channel state store: RAM of per-channel records with valid bits for reset values
module mwp_chan_store import mwp_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  chan_access_type access,
   output chan_state_type  rd_state
);

   localparam int STORE_DEPTH = 1 << CH_W;

   logic [STORE_DEPTH-1:0] valid_ff, valid_in;
   logic                   rd_valid_ff, rd_valid_in;
   logic [CS_W-1:0]        rd_word;

   mwp_ram #(
      .WIDTH (CS_W),
      .DEPTH (STORE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (access.wr_en),
      .wr_addr (access.wr_addr),
      .wr_data (access.wr_data),
      .rd_en   (access.rd_en),
      .rd_addr (access.rd_addr),
      .rd_data (rd_word)
   );

   // mark written entries, sample the valid bit alongside the read
   always_comb begin
      valid_in = valid_ff;
      if (access.wr_en) begin
         valid_in[access.wr_addr] = 1'b1;
      end
      rd_valid_in = access.rd_en ? valid_ff[access.rd_addr] : rd_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         rd_valid_ff <= rd_valid_in;
      end
   end

   // substitute the reset record for entries never written
   assign rd_state = rd_valid_ff ? chan_state_type'(rd_word) : CHAN_RESET;

endmodule

[design/multichannel_waveform_player_unit.sv]
// Multichannel waveform player: a sync tick advances every waveform channel and
// emits one DAC code per channel in channel order, the final one flagged last.
// A tick keeps the request side stalled; each channel costs one read and one
// write of the channel state memory, and the wave read overlaps the write. A
// stall on the result side holds the block until the pending code is taken. A
// sample write goes straight to the wave memory; selecting waveform mode or
// setting a fixed level reads, modifies and writes back the channel record. The
// channel state memory starts from its reset values through per-entry valid
// bits, so no clearing pass follows reset. The wave memory holds whatever was
// written; reading it only at written points is up to the user, not enforced.
module multichannel_waveform_player_unit import mwp_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [KIND_W-1:0]       req_kind,
   input  logic [CHAN_FIELD_W-1:0] req_channel,
   input  logic [INDEX_W-1:0]      req_point_index,
   input  logic [VALUE_W-1:0]      req_value,
   input  logic [LENGTH_W-1:0]     req_length,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [CHAN_FIELD_W-1:0] rsp_out_channel,
   output logic [VALUE_W-1:0]      rsp_dac_code,
   output logic                    rsp_last
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_UPDATE = 4'b0010,
      ST_CALC   = 4'b0100,
      ST_EMIT   = 4'b1000
   } state_type;

   state_type            state_ff, state_in;
   logic [CH_W-1:0]      chan_ff, chan_in;
   kind_type             kind_ff, kind_in;
   logic [LEN_W-1:0]     len_ff, len_in;
   logic [VALUE_W-1:0]   value_ff, value_in;
   logic                 mode_ff, mode_in;
   logic [VALUE_W-1:0]   level_ff, level_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [CHAN_FIELD_W-1:0] rsp_out_channel_ff;
   logic [VALUE_W-1:0]      rsp_dac_code_ff;
   logic                    rsp_last_ff;

   chan_access_type   access;
   chan_state_type    rd_state;
   chan_state_type    merged;

   logic              wave_wr_en, wave_rd_en;
   logic [WA_W-1:0]   wave_wr_addr, wave_rd_addr;
   logic [VALUE_W-1:0] wave_rd_data;

   logic              req_accept;
   logic [CH_W-1:0]   req_ch;
   logic              req_chan_ok, req_index_ok;
   logic [LEN_W-1:0]  req_len_sat;
   logic [LEN_W-1:0]  count_inc;
   logic [PT_W-1:0]   count_next;
   logic              in_frame, last_chan, rsp_free, load;

   mwp_chan_store u_chan_store (
      .clock    (clock),
      .reset    (reset),
      .access   (access),
      .rd_state (rd_state)
   );

   mwp_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (WAVE_DEPTH)
   ) u_wave_ram (
      .clock   (clock),
      .wr_en   (wave_wr_en),
      .wr_addr (wave_wr_addr),
      .wr_data (req_value),
      .rd_en   (wave_rd_en),
      .rd_addr (wave_rd_addr),
      .rd_data (wave_rd_data)
   );

   // decode the incoming transaction
   assign req_accept   = req_valid && !req_stall;
   assign req_ch       = CH_W'(req_channel);
   assign req_chan_ok  = 32'(req_channel) < 32'(CHANNELS);
   assign req_index_ok = 32'(req_point_index) < 32'(MAX_POINTS);
   assign req_len_sat  = (32'(req_length) < 32'(MAX_POINTS)) ? LEN_W'(req_length)
                                                            : LEN_W'(MAX_POINTS);

   // in waveform mode advance the point counter, wrap at the length
   assign count_inc  = LEN_W'(rd_state.counter) + LEN_W'(1);
   assign count_next = !rd_state.mode ? rd_state.counter :
                       (rd_state.length <= count_inc) ? '0 : PT_W'(count_inc);

   // wave memory addresses: channel row plus point
   assign wave_wr_addr = WA_W'(req_ch) * WA_W'(MAX_POINTS) + WA_W'(req_point_index);
   assign wave_rd_addr = WA_W'(chan_ff) * WA_W'(MAX_POINTS) + WA_W'(count_next);

   assign in_frame  = 32'(chan_ff) < 32'(FRAME);
   assign last_chan = chan_ff == CH_W'(CHANNELS - 1);
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = state_ff != ST_IDLE;

   // merge a mode or level update into the stored record
   always_comb begin
      merged = rd_state;
      if (kind_ff == KIND_WAVE) begin
         merged.length = len_ff;
         merged.mode   = 1'b1;
      end else begin
         merged.length = LEN_W'(1);
         merged.level  = value_ff;
         merged.mode   = 1'b0;
      end
   end

   // sequence the memory accesses
   always_comb begin
      state_in       = state_ff;
      chan_in        = chan_ff;
      kind_in        = kind_ff;
      len_in         = len_ff;
      value_in       = value_ff;
      mode_in        = mode_ff;
      level_in       = level_ff;
      access         = '0;
      wave_wr_en     = 1'b0;
      wave_rd_en     = 1'b0;
      load           = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               unique case (kind_type'(req_kind)) inside
                  KIND_TICK: begin
                     chan_in        = '0;
                     access.rd_en   = 1'b1;
                     access.rd_addr = '0;
                     state_in       = ST_CALC;
                  end
                  KIND_WRITE: begin
                     wave_wr_en = req_chan_ok && req_index_ok;
                  end
                  KIND_WAVE, KIND_FIXED: begin
                     if (req_chan_ok) begin
                        kind_in        = kind_type'(req_kind);
                        len_in         = req_len_sat;
                        value_in       = req_value;
                        chan_in        = req_ch;
                        access.rd_en   = 1'b1;
                        access.rd_addr = req_ch;
                        state_in       = ST_UPDATE;
                     end
                  end
               endcase
            end
         end
         ST_UPDATE: begin
            access.wr_en   = 1'b1;
            access.wr_addr = chan_ff;
            access.wr_data = merged;
            state_in       = ST_IDLE;
         end
         ST_CALC: begin
            access.wr_en           = 1'b1;
            access.wr_addr         = chan_ff;
            access.wr_data         = rd_state;
            access.wr_data.counter = count_next;
            wave_rd_en             = rd_state.mode;
            mode_in                = rd_state.mode;
            level_in               = rd_state.level;
            state_in               = ST_EMIT;
         end
         ST_EMIT: begin
            if (!in_frame || rsp_free) begin
               load = in_frame;
               if (last_chan) begin
                  state_in = ST_IDLE;
               end else begin
                  chan_in        = chan_ff + CH_W'(1);
                  access.rd_en   = 1'b1;
                  access.rd_addr = chan_ff + CH_W'(1);
                  state_in       = ST_CALC;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // hold a result until taken, drop it once taken
   assign rsp_valid_in = load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      chan_ff  <= chan_in;
      kind_ff  <= kind_in;
      len_ff   <= len_in;
      value_ff <= value_in;
      mode_ff  <= mode_in;
      level_ff <= level_in;
      if (load) begin
         rsp_out_channel_ff <= CHAN_FIELD_W'(chan_ff);
         rsp_dac_code_ff    <= mode_ff ? wave_rd_data : level_ff;
         rsp_last_ff        <= chan_ff == CH_W'(FRAME - 1);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_channel = rsp_out_channel_ff;
   assign rsp_dac_code    = rsp_dac_code_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

[design/mwp_checker.sv]
// Port-level checker of the waveform player, bound to the top level
`include "multichannel_waveform_player_unit_defines.svh"

module mwp_checker import mwp_pkg::*; (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_stall,
   input logic [KIND_W-1:0]       req_kind,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input logic [CHAN_FIELD_W-1:0] rsp_out_channel,
   input logic [VALUE_W-1:0]      rsp_dac_code,
   input logic                    rsp_last
);

   logic                            req_accept;
   logic [CHAN_FIELD_W+VALUE_W:0]   rsp_payload;

   assign req_accept  = req_valid && !req_stall;
   assign rsp_payload = {rsp_out_channel, rsp_dac_code, rsp_last};

   // a stalled result transaction holds
   `MWP_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_payload))

   // a tick keeps the request side stalled while the frame runs
   `MWP_ASSERT_NEXT(a_tick_busy, req_accept && req_kind == KIND_TICK, req_stall)

   // a frame still in progress blocks new transactions
   `MWP_ASSERT_SAME(a_frame_busy, rsp_valid && !rsp_last, req_stall)

   // non-tick transactions create no results
   `MWP_ASSERT_NEXT(a_no_spurious, req_accept && req_kind != KIND_TICK && !rsp_valid, !rsp_valid)

endmodule

bind multichannel_waveform_player_unit mwp_checker u_checker (.*);

[test/multichannel_waveform_player_unit_test.sv]
// Testbench of the multichannel waveform player: directed and random transactions, scoreboard
`timescale 1ns / 100ps

module multichannel_waveform_player_unit_test import mwp_pkg::*;;

   localparam int PERIOD        = 8;
   localparam int ITEMS         = 500;
   localparam int HOLD_CYCLES   = 400;
   localparam int DRAIN_CYCLES  = 80;
   localparam int LIMIT_NS      = 4_000_000;

   // one DAC code as it leaves the block
   typedef struct packed {
      logic [CHAN_FIELD_W-1:0] channel;
      logic [VALUE_W-1:0]      dac;
      logic                    last;
   } dac_code_type;

   // channel state mirror and queue of DAC codes still to arrive
   class dac_frame_board;
      logic [VALUE_W-1:0] wave_mem [WAVE_DEPTH];
      bit                 point_written [WAVE_DEPTH];
      int                 counter [CHANNELS];
      int                 wave_len [CHANNELS];
      bit                 wave_mode [CHANNELS];
      logic [VALUE_W-1:0] level [CHANNELS];
      dac_code_type       expected_codes [$];
      int                 mismatches;

      function new();
         for (int c = 0; c < CHANNELS; c++) begin
            counter[c]   = 0;
            wave_len[c]  = 1;
            wave_mode[c] = 1'b0;
            level[c]     = '0;
         end
         foreach (point_written[i]) point_written[i] = 1'b0;
         mismatches = 0;
      endfunction

      // point a waveform channel moves to on the next tick
      function int next_point(int c);
         int n;
         n = counter[c] + 1;
         if (wave_len[c] <= n) n = 0;
         return n;
      endfunction

      // apply an accepted transaction; a tick queues one code per channel
      function void note_command(kind_type kind, logic [CHAN_FIELD_W-1:0] ch,
                                 logic [INDEX_W-1:0] idx, logic [VALUE_W-1:0] sample,
                                 logic [LENGTH_W-1:0] length);
         dac_code_type code;
         int           p;
         if (kind == KIND_TICK) begin
            for (int c = 0; c < CHANNELS; c++)
               if (wave_mode[c]) counter[c] = next_point(c);
            for (int c = 0; c < FRAME; c++) begin
               p = (counter[c] < MAX_POINTS) ? counter[c] : 0;
               code.channel = CHAN_FIELD_W'(c);
               code.dac     = wave_mode[c] ? wave_mem[c * MAX_POINTS + p] : level[c];
               code.last    = (c == FRAME - 1);
               expected_codes.push_back(code);
            end
         end else if (int'(ch) < CHANNELS) begin
            case (kind)
               KIND_WRITE: begin
                  if (int'(idx) < MAX_POINTS) begin
                     wave_mem[int'(ch) * MAX_POINTS + int'(idx)]      = sample;
                     point_written[int'(ch) * MAX_POINTS + int'(idx)] = 1'b1;
                  end
               end
               KIND_WAVE: begin
                  wave_len[ch]  = (int'(length) < MAX_POINTS) ? int'(length) : MAX_POINTS;
                  wave_mode[ch] = 1'b1;
               end
               default: begin
                  wave_len[ch]  = 1;
                  level[ch]     = sample;
                  wave_mode[ch] = 1'b0;
               end
            endcase
         end
      endfunction

      // compare one accepted code with the oldest one due
      function void check_code(logic [CHAN_FIELD_W-1:0] ch, logic [VALUE_W-1:0] dac,
                               logic last);
         dac_code_type want;
         if (expected_codes.size() == 0) begin
            $error("DAC code for channel %0d arrived with none due", ch);
            mismatches++;
            return;
         end
         want = expected_codes.pop_front();
         if (ch !== want.channel) begin
            $error("out_channel: expected %0d, actual %0d", want.channel, ch);
            mismatches++;
         end
         if (dac !== want.dac) begin
            $error("dac_code: expected 0x%04h, actual 0x%04h", want.dac, dac);
            mismatches++;
         end
         if (last !== want.last) begin
            $error("last: expected %0b, actual %0b", want.last, last);
            mismatches++;
         end
      endfunction
   endclass

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   logic [KIND_W-1:0]       req_kind;
   logic [CHAN_FIELD_W-1:0] req_channel;
   logic [INDEX_W-1:0]      req_point_index;
   logic [VALUE_W-1:0]      req_value;
   logic [LENGTH_W-1:0]     req_length;
   logic                    rsp_valid;
   logic                    rsp_stall;
   logic [CHAN_FIELD_W-1:0] rsp_out_channel;
   logic [VALUE_W-1:0]      rsp_dac_code;
   logic                    rsp_last;

   dac_frame_board board = new();
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int items_sent    = 0;
   bit hold_request  = 1'b0;

   multichannel_waveform_player_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .req_channel     (req_channel),
      .req_point_index (req_point_index),
      .req_value       (req_value),
      .req_length      (req_length),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_channel (rsp_out_channel),
      .rsp_dac_code    (rsp_dac_code),
      .rsp_last        (rsp_last)
   );

   always #(PERIOD / 2) clock = ~clock;

   // offer one transaction after random idle cycles; hold it until accepted
   task automatic send_command(kind_type kind, logic [CHAN_FIELD_W-1:0] ch,
                               logic [INDEX_W-1:0] idx, logic [VALUE_W-1:0] sample,
                               logic [LENGTH_W-1:0] length);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_kind        <= kind;
      req_channel     <= ch;
      req_point_index <= idx;
      req_value       <= sample;
      req_length      <= length;
      do @(posedge clock); while (req_stall);
      board.note_command(kind, ch, idx, sample, length);
      items_sent++;
   endtask

   // write every point a waveform channel will reach, then tick with junk fields
   task automatic play_tick();
      int n;
      for (int c = 0; c < CHANNELS; c++) begin
         if (board.wave_mode[c]) begin
            n = board.next_point(c);
            if (!board.point_written[c * MAX_POINTS + n])
               send_command(KIND_WRITE, CHAN_FIELD_W'(c), INDEX_W'(n),
                            VALUE_W'($urandom), LENGTH_W'($urandom));
         end
      end
      send_command(KIND_TICK, CHAN_FIELD_W'($urandom), INDEX_W'($urandom),
                   VALUE_W'($urandom), LENGTH_W'($urandom));
   endtask

   // mostly short tables, now and then the saturating extremes
   function automatic logic [LENGTH_W-1:0] pick_length();
      int r;
      r = $urandom_range(99);
      if (r < 60) return LENGTH_W'($urandom_range(0, 8));
      if (r < 75) return LENGTH_W'($urandom_range(9, 64));
      if (r < 85) return LENGTH_W'($urandom_range(MAX_POINTS - 1, MAX_POINTS + 1));
      if (r < 90) return '1;
      return LENGTH_W'($urandom);
   endfunction

   task automatic send_random_command();
      int r;
      r = $urandom_range(99);
      if (r < 25)
         play_tick();
      else if (r < 60)
         send_command(KIND_WRITE, CHAN_FIELD_W'($urandom),
                      ($urandom_range(99) < 70) ? INDEX_W'($urandom_range(0, 15))
                                                : INDEX_W'($urandom),
                      VALUE_W'($urandom), LENGTH_W'($urandom));
      else if (r < 80)
         send_command(KIND_WAVE, CHAN_FIELD_W'($urandom), INDEX_W'($urandom),
                      VALUE_W'($urandom), pick_length());
      else
         send_command(KIND_FIXED, CHAN_FIELD_W'($urandom), INDEX_W'($urandom),
                      VALUE_W'($urandom), LENGTH_W'($urandom));
   endtask

   // result side: random stall, or a long counted hold-off on request
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            repeat (HOLD_CYCLES) begin
               rsp_stall <= 1'b1;
               @(posedge clock);
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // check every accepted DAC code
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_code(rsp_out_channel, rsp_dac_code, rsp_last);
   end

   // stimulus
   initial begin
      bit pressure_done;
      pressure_done = 1'b0;
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_kind        <= KIND_TICK;
      req_channel     <= '0;
      req_point_index <= '0;
      req_value       <= '0;
      req_length      <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 11;
      recv_idle_pct = 64;

      // fixed levels from reset, then the extremes of the level
      play_tick();
      send_command(KIND_FIXED, 4'd15, '0, 16'hFFFF, '1);
      send_command(KIND_FIXED, 4'd0, '1, 16'h0000, '0);
      // zero length, saturated length, short table
      send_command(KIND_WAVE, 4'd2, '0, '0, 16'd0);
      send_command(KIND_WAVE, 4'd3, '1, '1, 16'hFFFF);
      send_command(KIND_WAVE, 4'd4, '0, '0, 16'd3);
      send_command(KIND_WRITE, 4'd5, 10'd1023, 16'hFFFF, '1);
      play_tick();
      play_tick();
      // shorten the table below the counter: next tick wraps to zero
      send_command(KIND_WAVE, 4'd4, '0, '0, 16'd2);
      play_tick();
      // fixed level keeps the counter; waveform mode then resumes from it
      send_command(KIND_FIXED, 4'd3, '0, 16'h1234, '0);
      play_tick();
      send_command(KIND_WAVE, 4'd3, '0, '0, 16'd1025);
      play_tick();
      play_tick();

      // random part in three idling phases, pressure at the start of the last
      while (items_sent < ITEMS) begin
         if (items_sent < ITEMS / 3) begin
            send_idle_pct = 11;
            recv_idle_pct = 64;
         end else if (items_sent < 2 * ITEMS / 3) begin
            send_idle_pct = 64;
            recv_idle_pct = 11;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
            if (!pressure_done) begin
               hold_request  = 1'b1;
               pressure_done = 1'b1;
            end
         end
         send_random_command();
      end
      req_valid <= 1'b0;

      // drain outstanding codes, then watch for strays
      while (board.expected_codes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   // watchdog
   initial begin
      #(LIMIT_NS);
      $display("end of test: mismatches");
      $finish;
   end

endmodule
